// ===== rtl/core/cdsm_pkg.sv =====
// Shared types and constants for the disk-stamp cost grid.
// Used by the channel interfaces, the sweep engine, the grid RAM and the top level.
package cdsm_pkg;

    localparam int GRID_SIDE_DEF     = 200;
    localparam int FRAC_PER_CELL_DEF = 16;

    localparam int COST_W   = 7;
    localparam int COORD_W  = 14;
    localparam int STEP_W   = 7;
    localparam int IDX_IN_W = 8;
    localparam int RADIUS_W = 12;
    localparam int R2_W     = 2 * RADIUS_W;
    localparam int CFG_W    = RADIUS_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [COST_W-1:0] COST_MAX = 7'd127;

    localparam logic [RADIUS_W-1:0] DISK_RADIUS_RST = 12'd160;
    localparam logic [STEP_W-1:0]   HORIZON_RST     = 7'd35;

    localparam logic [CFG_IDX_W-1:0] REG_DISK_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZON     = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_STAMP = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef struct packed {
        logic                      clear;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic [COST_W-1:0]         cost;
        logic [R2_W-1:0]           r2;
    } sweep_cmd_t;

endpackage

// ===== rtl/core/cdsm_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on cdsm_pkg for field widths.
interface cdsm_req_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         operation;
    logic signed [cdsm_pkg::COORD_W-1:0] center_x;
    logic signed [cdsm_pkg::COORD_W-1:0] center_y;
    logic [cdsm_pkg::STEP_W-1:0]        pred_step;
    logic [cdsm_pkg::IDX_IN_W-1:0]      cell_column;
    logic [cdsm_pkg::IDX_IN_W-1:0]      cell_row;

    modport source (
        output valid, operation, center_x, center_y, pred_step, cell_column, cell_row,
        input  ready
    );
    modport sink (
        input  valid, operation, center_x, center_y, pred_step, cell_column, cell_row,
        output ready
    );
endinterface

interface cdsm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [cdsm_pkg::COST_W-1:0] cell_cost;
    logic                        op_done;

    modport source (output valid, cell_cost, op_done, input ready);
    modport sink   (input valid, cell_cost, op_done, output ready);
endinterface

// ===== rtl/core/costmap_disk_stamp_max.sv =====
// Cost grid of GRID_SIDE x GRID_SIDE 7-bit cells held in one synchronous RAM.
// Clear and stamp each run one sweep over the grid: the sweep engine visits one cell
// per cycle through a four-stage read-modify-write pipeline on the RAM's single read
// and write ports. A read passes through the read and read-data states before its
// response; an unused operation code or a stamp whose step lies beyond the horizon
// answers without touching the RAM. One request is in flight at a time; the next
// request is taken while a response still waits on the output register. After reset
// a clearing pass over the whole grid runs before the first request is taken;
// configuration writes are taken at any time.
module costmap_disk_stamp_max #(
    parameter int GRID_SIDE     = cdsm_pkg::GRID_SIDE_DEF,
    parameter int FRAC_PER_CELL = cdsm_pkg::FRAC_PER_CELL_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    cdsm_req_if.sink                       req,
    cdsm_rsp_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic [cdsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cdsm_pkg::CFG_W-1:0]     cfg_data
);
    import cdsm_pkg::*;

    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(CELLS);

    typedef enum logic [6:0] {
        ST_BOOT      = 7'b0000001,
        ST_BOOT_WAIT = 7'b0000010,
        ST_IDLE      = 7'b0000100,
        ST_SWEEP     = 7'b0001000,
        ST_READ      = 7'b0010000,
        ST_RDATA     = 7'b0100000,
        ST_DONE      = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [RADIUS_W-1:0] disk_radius_reg;
    logic [STEP_W-1:0]   horizon_steps_reg;

    logic [ADDR_W-1:0] read_addr_reg, read_addr_next;
    logic [COST_W-1:0] res_cost_reg, res_cost_next;
    logic              res_done_reg, res_done_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [COST_W-1:0] rsp_cost_reg;
    logic              rsp_done_reg;
    logic              rsp_load;

    logic              accept;
    logic              sweep_start;
    sweep_cmd_t        sweep_cmd;
    logic              sweep_done;
    logic              sweep_rd_en, sweep_wr_en;
    logic [ADDR_W-1:0] sweep_rd_addr, sweep_wr_addr;
    logic [COST_W-1:0] sweep_wr_data;

    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [COST_W-1:0] ram_rd_data;

    logic signed [STEP_W+1:0] stamp_cost;
    logic [R2_W-1:0]          radius_sq;
    logic                     read_in_range;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);

    assign stamp_cost = $signed({2'b00, horizon_steps_reg}) - $signed({2'b00, req.pred_step})
                        + $signed((STEP_W + 2)'(1));
    assign radius_sq  = R2_W'(disk_radius_reg) * R2_W'(disk_radius_reg);
    assign read_in_range = ((IDX_IN_W + 1)'(req.cell_column) < (IDX_IN_W + 1)'(GRID_SIDE))
                        && ((IDX_IN_W + 1)'(req.cell_row) < (IDX_IN_W + 1)'(GRID_SIDE));

    always_comb
    begin
        sweep_cmd.clear    = (state_reg == ST_BOOT) || (req.operation == OP_CLEAR);
        sweep_cmd.center_x = req.center_x;
        sweep_cmd.center_y = req.center_y;
        sweep_cmd.r2       = radius_sq;
        if (stamp_cost > $signed((STEP_W + 2)'(COST_MAX)))
        begin
            sweep_cmd.cost = COST_MAX;
        end
        else
        begin
            sweep_cmd.cost = stamp_cost[COST_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sweep_start    = 1'b0;
        read_addr_next = read_addr_reg;
        res_cost_next  = res_cost_reg;
        res_done_next  = res_done_reg;
        rsp_load       = 1'b0;
        case (state_reg)
            ST_BOOT:
            begin
                sweep_start = 1'b1;
                state_next  = ST_BOOT_WAIT;
            end
            ST_BOOT_WAIT:
            begin
                if (sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_cost_next = '0;
                    res_done_next = 1'b1;
                    case (req.operation)
                        OP_CLEAR:
                        begin
                            sweep_start = 1'b1;
                            state_next  = ST_SWEEP;
                        end
                        OP_STAMP:
                        begin
                            // step beyond horizon leaves the grid untouched
                            if (stamp_cost > $signed((STEP_W + 2)'(0)))
                            begin
                                sweep_start = 1'b1;
                                state_next  = ST_SWEEP;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        OP_READ:
                        begin
                            if (read_in_range)
                            begin
                                read_addr_next = ADDR_W'(req.cell_row) * ADDR_W'(GRID_SIDE)
                                               + ADDR_W'(req.cell_column);
                                state_next     = ST_READ;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            res_done_next = 1'b0;
                            state_next    = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_RDATA;
            end
            ST_RDATA:
            begin
                res_cost_next = ram_rd_data;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_BOOT;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_BOOT;
            rsp_valid_reg     <= 1'b0;
            disk_radius_reg   <= DISK_RADIUS_RST;
            horizon_steps_reg <= HORIZON_RST;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DISK_RADIUS: disk_radius_reg   <= cfg_data[RADIUS_W-1:0];
                    REG_HORIZON:     horizon_steps_reg <= cfg_data[STEP_W-1:0];
                    default:         disk_radius_reg   <= disk_radius_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        read_addr_reg <= read_addr_next;
        res_cost_reg  <= res_cost_next;
        res_done_reg  <= res_done_next;
        if (rsp_load)
        begin
            rsp_cost_reg <= res_cost_reg;
            rsp_done_reg <= res_done_reg;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.cell_cost = rsp_cost_reg;
    assign rsp.op_done   = rsp_done_reg;

    assign ram_rd_en   = sweep_rd_en || (state_reg == ST_READ);
    assign ram_rd_addr = (state_reg == ST_READ) ? read_addr_reg : sweep_rd_addr;

    cdsm_sweep #(
        .GRID_SIDE     (GRID_SIDE),
        .FRAC_PER_CELL (FRAC_PER_CELL)
    ) u_sweep (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sweep_start),
        .cmd     (sweep_cmd),
        .done    (sweep_done),
        .rd_en   (sweep_rd_en),
        .rd_addr (sweep_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (sweep_wr_en),
        .wr_addr (sweep_wr_addr),
        .wr_data (sweep_wr_data)
    );

    cdsm_grid_ram #(
        .CELLS (CELLS)
    ) u_grid_ram (
        .clk     (clk),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (sweep_wr_en),
        .wr_addr (sweep_wr_addr),
        .wr_data (sweep_wr_data)
    );

endmodule

// ===== rtl/core/cdsm_grid_ram.sv =====
// Cost grid storage: one write port, one read port, registered read data.
// Depends on cdsm_pkg for the cost width.
module cdsm_grid_ram #(
    parameter int  CELLS = cdsm_pkg::GRID_SIDE_DEF * cdsm_pkg::GRID_SIDE_DEF,
    localparam int ADDR_W = $clog2(CELLS)
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [cdsm_pkg::COST_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [cdsm_pkg::COST_W-1:0] wr_data
);
    import cdsm_pkg::*;

    logic [COST_W-1:0] mem [CELLS];
    logic [COST_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/cdsm_sweep.sv =====
// Sweep engine: walks every cell once, computes the squared distance to the disk
// centre in a short pipeline and does the read-modify-write. Depends on cdsm_pkg.
module cdsm_sweep #(
    parameter int  GRID_SIDE     = cdsm_pkg::GRID_SIDE_DEF,
    parameter int  FRAC_PER_CELL = cdsm_pkg::FRAC_PER_CELL_DEF,
    localparam int ADDR_W        = $clog2(GRID_SIDE * GRID_SIDE)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  cdsm_pkg::sweep_cmd_t        cmd,
    output logic                        done,
    output logic                        rd_en,
    output logic [ADDR_W-1:0]           rd_addr,
    input  logic [cdsm_pkg::COST_W-1:0] rd_data,
    output logic                        wr_en,
    output logic [ADDR_W-1:0]           wr_addr,
    output logic [cdsm_pkg::COST_W-1:0] wr_data
);
    import cdsm_pkg::*;

    localparam int CELLS   = GRID_SIDE * GRID_SIDE;
    localparam int HALF    = GRID_SIDE / 2;
    localparam int IDX_W   = $clog2(GRID_SIDE);
    localparam int DELTA_W = $clog2((1 << (COORD_W - 1)) + FRAC_PER_CELL * HALF + 1) + 1;
    localparam int SQ_W    = 2 * DELTA_W - 2;
    localparam int CMP_W   = (SQ_W + 1 > R2_W) ? SQ_W + 1 : R2_W;

    sweep_cmd_t cmd_reg;

    // stage 0: cell counters
    logic              run_reg, run_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              last0;

    // stage 1: offsets
    logic                      v1_reg, last1_reg;
    logic [ADDR_W-1:0]         addr1_reg;
    logic signed [DELTA_W-1:0] dx1_reg, dy1_reg;

    // stage 2: squares, memory read issued
    logic                      v2_reg, last2_reg;
    logic [ADDR_W-1:0]         addr2_reg;
    logic [SQ_W-1:0]           sqx2_reg, sqy2_reg;

    // stage 3: compare result, read data back, write
    logic                      v3_reg, last3_reg, inside3_reg;
    logic [ADDR_W-1:0]         addr3_reg;

    logic signed [DELTA_W-1:0]   col_off, row_off, pos_x, pos_y, dx0, dy0;
    logic signed [2*DELTA_W-1:0] sqx_full, sqy_full;
    logic [CMP_W-1:0]            dist2, r2_ext;

    assign last0 = (addr_reg == ADDR_W'(CELLS - 1));

    always_comb
    begin
        run_next  = run_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        addr_next = addr_reg;
        if (start)
        begin
            run_next  = 1'b1;
            row_next  = '0;
            col_next  = '0;
            addr_next = '0;
        end
        else if (run_reg)
        begin
            addr_next = addr_reg + ADDR_W'(1);
            if (col_reg == IDX_W'(GRID_SIDE - 1))
            begin
                col_next = '0;
                row_next = row_reg + IDX_W'(1);
            end
            else
            begin
                col_next = col_reg + IDX_W'(1);
            end
            if (last0)
            begin
                run_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        col_off = $signed(DELTA_W'(col_reg)) - $signed(DELTA_W'(HALF));
        row_off = $signed(DELTA_W'(row_reg)) - $signed(DELTA_W'(HALF));
        pos_x   = col_off * $signed(DELTA_W'(FRAC_PER_CELL));
        pos_y   = row_off * $signed(DELTA_W'(FRAC_PER_CELL));
        dx0     = $signed(DELTA_W'(cmd_reg.center_x)) - pos_x;
        dy0     = $signed(DELTA_W'(cmd_reg.center_y)) - pos_y;
    end

    assign sqx_full = dx1_reg * dx1_reg;
    assign sqy_full = dy1_reg * dy1_reg;
    assign dist2    = CMP_W'(sqx2_reg) + CMP_W'(sqy2_reg);
    assign r2_ext   = CMP_W'(cmd_reg.r2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
            addr_reg  <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            last1_reg <= 1'b0;
            last2_reg <= 1'b0;
            last3_reg <= 1'b0;
        end
        else
        begin
            run_reg   <= run_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            addr_reg  <= addr_next;
            v1_reg    <= run_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            last1_reg <= run_reg && last0;
            last2_reg <= last1_reg;
            last3_reg <= last2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg <= cmd;
        end
        addr1_reg   <= addr_reg;
        dx1_reg     <= dx0;
        dy1_reg     <= dy0;
        addr2_reg   <= addr1_reg;
        sqx2_reg    <= sqx_full[SQ_W-1:0];
        sqy2_reg    <= sqy_full[SQ_W-1:0];
        addr3_reg   <= addr2_reg;
        inside3_reg <= (dist2 < r2_ext);
    end

    assign rd_en   = v2_reg;
    assign rd_addr = addr2_reg;

    // raise only; clear writes zero everywhere
    assign wr_en   = v3_reg && (cmd_reg.clear || (inside3_reg && (cmd_reg.cost > rd_data)));
    assign wr_addr = addr3_reg;
    assign wr_data = cmd_reg.clear ? '0 : cmd_reg.cost;
    assign done    = v3_reg && last3_reg;

endmodule
